// ===== design/ups_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers for the URL path sanitiser.
// Used by ups_ctrl, ups_dp and url_path_sanitizer; depends on nothing.

package ups_pkg;

  localparam int PATH_BYTES_DEF = 64;
  localparam int PREFIX_LEN     = 8;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_DOTDOT = 2'd1,
    STAT_NUL    = 2'd2,
    STAT_LONG   = 2'd3
  } ups_status_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX  = 2'd2,
    ESC_RSVD = 2'd3
  } ups_esc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHAR,
    ST_FLUSH,
    ST_CLOSE,
    ST_JUDGE,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_STATUS
  } ups_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic flush;
    logic char_step;
    logic close;
    logic emit_byte;
    logic emit_status;
    logic clear;
  } ups_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic item_last;
    logic failed;
    logic out_free;
    logic emit_last;
  } ups_sts_t;

  function automatic logic ups_hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] ups_hex_val(input logic [7:0] c);
    logic [7:0] d;
    begin
      priority if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end else begin
        d = 8'h00;
      end
      return d[3:0];
    end
  endfunction

  function automatic logic [7:0] ups_prefix(input logic [2:0] idx);
    logic [7:0] b;
    begin
      unique case (idx)
        3'd0: b = 8'h2F;
        3'd1: b = 8'h70;
        3'd2: b = 8'h61;
        3'd3: b = 8'h70;
        3'd4: b = 8'h65;
        3'd5: b = 8'h72;
        3'd6: b = 8'h6F;
        3'd7: b = 8'h73;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/ups_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath: escape decoding, character queue, segment buffer and result register.
// Depends on ups_pkg; driven by commands from ups_ctrl.

module ups_dp #(
  parameter int PATH_BYTES = ups_pkg::PATH_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ups_pkg::ups_cmd_t cmd,
  output ups_pkg::ups_sts_t      sts,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end_only,
  input  wire logic              in_last,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic [1:0]             out_status
);
  import ups_pkg::*;

  localparam int BufDepth = PATH_BYTES - PREFIX_LEN;
  localparam int AW       = $clog2(BufDepth);
  localparam int WPW      = $clog2(BufDepth + 1);
  localparam int KW       = $clog2(PATH_BYTES + 1);

  logic [7:0]     byte_r;
  logic           eo_r;
  logic           last_r;

  ups_esc_t       esc_r, esc_nxt;
  logic [7:0]     held_r, held_nxt;
  logic [WPW-1:0] wp_r, wp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           all_dots_r, all_dots_nxt;
  ups_status_t    fail_r, fail_nxt;
  logic [7:0]     q_r [3];
  logic [7:0]     q_nxt [3];
  logic [2:0]     q_pl_r, q_pl_nxt;
  logic [1:0]     q_cnt_r, q_cnt_nxt;
  logic [KW-1:0]  k_r, k_nxt;

  logic           fail_ev;
  ups_status_t    fail_code;
  logic           put_en;
  logic           mem_we;
  logic [7:0]     put_chr;
  logic           pop;

  logic [7:0]     mem [BufDepth];
  logic [7:0]     rd_data_r;
  logic [KW-1:0]  k_off;
  logic [KW-1:0]  k_inc;
  logic [KW-1:0]  total;

  logic           out_valid_r;
  logic [7:0]     out_byte_r;
  logic           out_last_r;
  ups_status_t    out_status_r;

  function automatic logic [1:0] fail_rank(input ups_status_t c);
    logic [1:0] r;
    begin
      unique case (c)
        STAT_NUL:    r = 2'd3;
        STAT_DOTDOT: r = 2'd2;
        STAT_LONG:   r = 2'd1;
        STAT_OK:     r = 2'd0;
        default:     r = 2'd0;
      endcase
      return r;
    end
  endfunction

  assign k_off = k_r - KW'(PREFIX_LEN);
  assign k_inc = k_r + KW'(1);
  assign total = KW'(PREFIX_LEN) + KW'(wp_r);

  always_comb begin
    esc_nxt      = esc_r;
    held_nxt     = held_r;
    wp_nxt       = wp_r;
    cnt_nxt      = cnt_r;
    all_dots_nxt = all_dots_r;
    q_nxt        = q_r;
    q_pl_nxt     = q_pl_r;
    q_cnt_nxt    = q_cnt_r;
    k_nxt        = k_r;
    fail_ev      = 1'b0;
    fail_code    = STAT_OK;
    put_en       = 1'b0;
    mem_we       = 1'b0;
    put_chr      = q_r[0];
    pop          = 1'b0;

    if (cmd.decode) begin
      q_cnt_nxt = 2'd0;
      if (!eo_r) begin
        unique case (esc_r)
          ESC_PCT: begin
            if (ups_hex_ok(byte_r)) begin
              held_nxt = byte_r;
              esc_nxt  = ESC_HEX;
            end else begin
              esc_nxt   = ESC_NONE;
              q_nxt[0]  = CHR_PCT;
              q_nxt[1]  = byte_r;
              q_pl_nxt  = 3'b010;
              q_cnt_nxt = 2'd2;
            end
          end
          ESC_HEX: begin
            esc_nxt = ESC_NONE;
            if (ups_hex_ok(held_r) && ups_hex_ok(byte_r)) begin
              q_nxt[0]  = {ups_hex_val(held_r), ups_hex_val(byte_r)};
              q_pl_nxt  = 3'b000;
              q_cnt_nxt = 2'd1;
            end else begin
              q_nxt[0]  = CHR_PCT;
              q_nxt[1]  = held_r;
              q_nxt[2]  = byte_r;
              q_pl_nxt  = 3'b100;
              q_cnt_nxt = 2'd3;
            end
          end
          default: begin
            esc_nxt   = ESC_NONE;
            q_nxt[0]  = byte_r;
            q_pl_nxt  = 3'b001;
            q_cnt_nxt = 2'd1;
          end
        endcase
      end
    end

    if (cmd.flush) begin
      esc_nxt  = ESC_NONE;
      q_pl_nxt = 3'b000;
      q_nxt[0] = CHR_PCT;
      q_nxt[1] = held_r;
      unique case (esc_r)
        ESC_PCT: q_cnt_nxt = 2'd1;
        ESC_HEX: q_cnt_nxt = 2'd2;
        default: q_cnt_nxt = 2'd0;
      endcase
    end

    if (cmd.char_step) begin
      priority if (q_pl_r[0] && q_r[0] == CHR_PCT) begin
        esc_nxt = ESC_PCT;
        pop     = 1'b1;
      end else if (q_r[0] == CHR_NUL) begin
        fail_ev   = 1'b1;
        fail_code = STAT_NUL;
        pop       = 1'b1;
      end else if (q_r[0] == CHR_SLASH) begin
        if (all_dots_r && cnt_r == 2'd2) begin
          fail_ev   = 1'b1;
          fail_code = STAT_DOTDOT;
        end
        cnt_nxt      = 2'd0;
        all_dots_nxt = 1'b1;
        pop          = 1'b1;
      end else if (all_dots_r) begin
        if (q_r[0] == CHR_DOT && cnt_r != 2'd2) begin
          cnt_nxt = cnt_r + 2'd1;
          pop     = 1'b1;
        end else begin
          put_en       = 1'b1;
          put_chr      = CHR_SLASH;
          all_dots_nxt = 1'b0;
        end
      end else if (cnt_r != 2'd0) begin
        put_en  = 1'b1;
        put_chr = CHR_DOT;
        cnt_nxt = cnt_r - 2'd1;
      end else begin
        put_en = 1'b1;
        pop    = 1'b1;
      end
    end

    if (pop) begin
      q_nxt[0]  = q_r[1];
      q_nxt[1]  = q_r[2];
      q_pl_nxt  = {1'b0, q_pl_r[2:1]};
      q_cnt_nxt = q_cnt_r - 2'd1;
    end

    if (put_en) begin
      if (wp_r < WPW'(BufDepth)) begin
        mem_we = 1'b1;
        wp_nxt = wp_r + WPW'(1);
      end else begin
        fail_ev   = 1'b1;
        fail_code = STAT_LONG;
      end
    end

    if (cmd.close) begin
      if (all_dots_r && cnt_r == 2'd2) begin
        fail_ev   = 1'b1;
        fail_code = STAT_DOTDOT;
      end
      cnt_nxt      = 2'd0;
      all_dots_nxt = 1'b1;
    end

    if (cmd.emit_byte) begin
      k_nxt = k_inc;
    end

    fail_nxt = (fail_ev && fail_rank(fail_code) > fail_rank(fail_r)) ? fail_code : fail_r;

    if (cmd.clear) begin
      esc_nxt      = ESC_NONE;
      held_nxt     = 8'h00;
      wp_nxt       = '0;
      cnt_nxt      = 2'd0;
      all_dots_nxt = 1'b1;
      fail_nxt     = STAT_OK;
      q_cnt_nxt    = 2'd0;
      k_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r      <= ESC_NONE;
      held_r     <= 8'h00;
      wp_r       <= '0;
      cnt_r      <= 2'd0;
      all_dots_r <= 1'b1;
      fail_r     <= STAT_OK;
      q_cnt_r    <= 2'd0;
      k_r        <= '0;
    end else begin
      esc_r      <= esc_nxt;
      held_r     <= held_nxt;
      wp_r       <= wp_nxt;
      cnt_r      <= cnt_nxt;
      all_dots_r <= all_dots_nxt;
      fail_r     <= fail_nxt;
      q_cnt_r    <= q_cnt_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    q_pl_r <= q_pl_nxt;
    if (cmd.load) begin
      byte_r <= in_byte;
      eo_r   <= in_end_only;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r[AW-1:0]] <= put_chr;
    end
    rd_data_r <= mem[k_off[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_status) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte_r   <= (k_r < KW'(PREFIX_LEN)) ? ups_prefix(k_r[2:0]) : rd_data_r;
      out_last_r   <= (k_inc == total);
      out_status_r <= STAT_OK;
    end else if (cmd.emit_status) begin
      out_byte_r   <= 8'h00;
      out_last_r   <= 1'b1;
      out_status_r <= fail_r;
    end
  end

  assign sts.q_empty   = (q_cnt_r == 2'd0);
  assign sts.item_last = last_r;
  assign sts.failed    = (fail_r != STAT_OK);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.emit_last = (k_inc == total);

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// ===== design/ups_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine: sequences decode, character steps, close-out and emission.
// Depends on ups_pkg; commands ups_dp through ups_cmd_t, reads back ups_sts_t.

module ups_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ups_pkg::ups_sts_t sts,
  output ups_pkg::ups_cmd_t      cmd
);
  import ups_pkg::*;

  ups_state_t state_r, state_nxt;
  logic       flushed_r, flushed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      flushed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      flushed_r <= flushed_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    flushed_nxt = flushed_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          flushed_nxt = 1'b0;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_CHAR;
      end
      ST_CHAR: begin
        priority if (!sts.q_empty) begin
          cmd.char_step = 1'b1;
        end else if (!sts.item_last) begin
          state_nxt = ST_IDLE;
        end else if (!flushed_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_FLUSH: begin
        cmd.flush   = 1'b1;
        flushed_nxt = 1'b1;
        state_nxt   = ST_CHAR;
      end
      ST_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        state_nxt = sts.failed ? ST_STATUS : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_byte = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.clear       = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/url_path_sanitizer.sv =====
// URL path sanitiser: takes one raw path byte per request (none if end-only), percent-decodes
// it, splits on '/', drops "." segments and buffers the kept segments; on the request marked
// last it sends the fixed eight-byte prefix followed by "/segment" for each kept segment, or a
// single status-only result (dot-dot, NUL, too long) with no path bytes. Timing is set by the
// controller, which walks one decoded character or one buffer write per cycle: a request
// passes through load and decode, then one step per queued character and one per buffer
// write that consumes no character (the leading '/' of a segment and any held dots). The last
// request adds a close-out (flush, steps for a pending escape, close, judge), then a
// buffer read and an output write per result byte (the segment buffer has a registered read
// port) or one output write for a status-only result. There is no clearing pass after reset.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module url_path_sanitizer #(
  parameter int PATH_BYTES = ups_pkg::PATH_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_only,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [1:0]      out_status
);
  import ups_pkg::*;

  ups_cmd_t cmd;
  ups_sts_t sts;

  ups_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ups_dp #(
    .PATH_BYTES (PATH_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_byte     (in_byte),
    .in_end_only (in_end_only),
    .in_last     (in_last),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_status  (out_status)
  );

  a_no_emit_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.emit_byte || cmd.emit_status))
    else $error("result loaded while taking requests");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_last && out_byte == 8'h00))
    else $error("failure result is not status-only");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken before the first was processed");

  a_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (in_ready && out_valid && out_last))
    else $error("path close-out did not return to idle with final result");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for url_path_sanitizer: directed paths, then random paths.
// Holds its own percent-decode and path-normalise predictor; depends on ups_pkg and the RTL.

module tb;
  import ups_pkg::*;

  localparam int PATH_LIMIT = PATH_BYTES_DEF;
  localparam int BUF_SLOTS = 56;
  localparam int KEEP_CAP = (PATH_LIMIT - PREFIX_LEN < BUF_SLOTS) ? PATH_LIMIT - PREFIX_LEN
                                                                  : BUF_SLOTS;
  localparam logic [63:0] LEAD_BYTES = 64'h2F70_6170_6572_6F73;
  localparam int DIR_COUNT = 25;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    ups_status_t st;
  } path_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eo;
    logic       last;
  } stim_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eo;
    logic        last;
    logic        typed;
    ups_status_t st;
  } dir_row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_only = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] out_status;

  path_out_t awaited[$];
  int errors = 0;
  int n_items = 0;
  int n_paths = 0;
  int n_path_bytes = 0;
  int n_rejects = 0;
  bit calm = 1'b0;
  int ready_left = 0;

  // predictor state
  ups_esc_t    esc_phase = ESC_NONE;
  logic [7:0]  held_digit = 8'h00;
  logic [7:0]  kept_bytes [BUF_SLOTS];
  int          fill = 0;
  int          dots = 0;
  bit          only_dots = 1'b1;
  ups_status_t verdict = STAT_OK;

  dir_row_t dir_rows [DIR_COUNT] = '{
    '{8'h00,     1'b1, 1'b1, 1'b0, STAT_OK},
    '{CHR_PCT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{"0",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{"0",       1'b0, 1'b1, 1'b1, STAT_NUL},
    '{CHR_SLASH, 1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_DOT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_DOT,   1'b0, 1'b1, 1'b1, STAT_DOTDOT},
    '{CHR_DOT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_SLASH, 1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_PCT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{"4",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{"A",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_PCT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{"2",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{"f",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_PCT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{"g",       1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_PCT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{"4",       1'b0, 1'b1, 1'b0, STAT_OK},
    '{8'hFF,     1'b0, 1'b0, 1'b0, STAT_OK},
    '{8'h00,     1'b1, 1'b0, 1'b0, STAT_OK},
    '{8'hA5,     1'b1, 1'b1, 1'b0, STAT_OK},
    '{CHR_DOT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_DOT,   1'b0, 1'b0, 1'b0, STAT_OK},
    '{CHR_NUL,   1'b0, 1'b1, 1'b1, STAT_NUL}
  };

  url_path_sanitizer #(.PATH_BYTES(PATH_LIMIT)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_end_only(in_end_only),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void append_out(ref path_out_t q[$], input path_out_t r);
    q = {q, r};
  endfunction

  function automatic void append_stim(ref stim_t q[$], input stim_t s);
    q = {q, s};
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic int severity(ups_status_t s);
    case (s)
      STAT_NUL:    return 3;
      STAT_DOTDOT: return 2;
      STAT_LONG:   return 1;
      default:     return 0;
    endcase
  endfunction

  function automatic void raise_verdict(ups_status_t s);
    if (severity(s) > severity(verdict)) verdict = s;
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    if (fill < KEEP_CAP) begin
      kept_bytes[fill] = c;
      fill++;
    end else begin
      raise_verdict(STAT_LONG);
    end
  endfunction

  function automatic void close_segment();
    if (only_dots && dots == 2) raise_verdict(STAT_DOTDOT);
    dots = 0;
    only_dots = 1'b1;
  endfunction

  function automatic void take_decoded(logic [7:0] c);
    int k;
    if (c == CHR_NUL) begin
      raise_verdict(STAT_NUL);
      return;
    end
    if (c == CHR_SLASH) begin
      close_segment();
      return;
    end
    if (only_dots) begin
      if (c == CHR_DOT && dots < 2) begin
        dots++;
        return;
      end
      keep_byte(CHR_SLASH);
      for (k = 0; k < dots; k++) keep_byte(CHR_DOT);
      only_dots = 1'b0;
    end
    keep_byte(c);
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == CHR_PCT) esc_phase = ESC_PCT;
    else take_decoded(c);
  endfunction

  function automatic void take_raw(logic [7:0] c);
    int hi;
    int lo;
    logic [7:0] val;
    case (esc_phase)
      ESC_PCT: begin
        if (hex_digit(c) >= 0) begin
          held_digit = c;
          esc_phase = ESC_HEX;
        end else begin
          esc_phase = ESC_NONE;
          take_decoded(CHR_PCT);
          take_plain(c);
        end
      end
      ESC_HEX: begin
        hi = hex_digit(held_digit);
        lo = hex_digit(c);
        esc_phase = ESC_NONE;
        if (hi >= 0 && lo >= 0) begin
          val = {hi[3:0], lo[3:0]};
          take_decoded(val);
        end else begin
          take_decoded(CHR_PCT);
          take_decoded(held_digit);
          take_plain(c);
        end
      end
      default: begin
        esc_phase = ESC_NONE;
        take_plain(c);
      end
    endcase
  endfunction

  function automatic void sanitize_request(logic [7:0] d, bit eo, bit last,
                                           ref path_out_t res[$]);
    int total;
    int k;
    logic [7:0] b;
    res.delete();
    if (!eo) take_raw(d);
    if (!last) return;
    if (esc_phase == ESC_PCT) begin
      take_decoded(CHR_PCT);
    end else if (esc_phase == ESC_HEX) begin
      take_decoded(CHR_PCT);
      take_decoded(held_digit);
    end
    esc_phase = ESC_NONE;
    close_segment();
    if (verdict != STAT_OK) begin
      append_out(res, '{8'h00, 1'b1, verdict});
    end else begin
      total = PREFIX_LEN + fill;
      for (k = 0; k < total; k++) begin
        b = (k < PREFIX_LEN) ? LEAD_BYTES[63 - 8 * k -: 8] : kept_bytes[k - PREFIX_LEN];
        append_out(res, '{b, k + 1 == total, STAT_OK});
      end
    end
    held_digit = 8'h00;
    fill = 0;
    dots = 0;
    only_dots = 1'b1;
    verdict = STAT_OK;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(int v, bit upper);
    if (v < 10) return 8'(8'h30 + v);
    return 8'((upper ? 8'h41 : 8'h61) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  task automatic flag_mismatch(string msg);
    if (errors < 100) $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic send_req(logic [7:0] d, bit eo, bit last, bit counted,
                          bit typed, ups_status_t typed_st);
    path_out_t res[$];
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= d;
    in_end_only <= eo;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    sanitize_request(d, eo, last, res);
    if (typed && last) append_out(awaited, '{8'h00, 1'b1, typed_st});
    else foreach (res[i]) append_out(awaited, res[i]);
    if (counted) n_items++;
    if (last) n_paths++;
  endtask

  task automatic random_path(bit lengthy);
    stim_t seq[$];
    int n;
    int i;
    int v;
    n = lengthy ? $urandom_range(58, 66) : $urandom_range(0, 14);
    for (i = 0; i < n; i++) begin
      v = $urandom_range(0, 99);
      if (lengthy) begin
        if (v < 8) append_stim(seq, '{CHR_SLASH, 1'b0, 1'b0});
        else if (v < 9) append_stim(seq, '{CHR_DOT, 1'b0, 1'b0});
        else append_stim(seq, '{8'h61 + 8'($urandom_range(0, 25)), 1'b0, 1'b0});
      end else if (v < 10) begin
        append_stim(seq, '{CHR_SLASH, 1'b0, 1'b0});
      end else if (v < 20) begin
        append_stim(seq, '{CHR_DOT, 1'b0, 1'b0});
      end else if (v < 32) begin
        append_stim(seq, '{CHR_PCT, 1'b0, 1'b0});
        append_stim(seq, '{hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0, 1'b0});
        append_stim(seq, '{hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0, 1'b0});
      end else if (v < 36) begin
        append_stim(seq, '{CHR_PCT, 1'b0, 1'b0});
        append_stim(seq, '{non_hex(), 1'b0, 1'b0});
      end else if (v < 39) begin
        append_stim(seq, '{CHR_PCT, 1'b0, 1'b0});
        append_stim(seq, '{hex_char($urandom_range(0, 15), $urandom_range(0, 1)), 1'b0, 1'b0});
        append_stim(seq, '{non_hex(), 1'b0, 1'b0});
      end else if (v < 42) begin
        append_stim(seq, '{CHR_PCT, 1'b0, 1'b0});
      end else if (v < 44) begin
        append_stim(seq, '{CHR_NUL, 1'b0, 1'b0});
      end else if (v < 54) begin
        append_stim(seq, '{8'($urandom_range(0, 255)), 1'b0, 1'b0});
      end else begin
        append_stim(seq, '{8'h61 + 8'($urandom_range(0, 25)), 1'b0, 1'b0});
      end
    end
    if (lengthy && $urandom_range(0, 1)) begin
      append_stim(seq, '{CHR_SLASH, 1'b0, 1'b0});
      append_stim(seq, '{CHR_DOT, 1'b0, 1'b0});
      append_stim(seq, '{CHR_DOT, 1'b0, 1'b0});
    end
    if (seq.size() == 0 || $urandom_range(0, 2) == 0) append_stim(seq, '{8'($urandom), 1'b1, 1'b1});
    else seq[seq.size() - 1].last = 1'b1;
    foreach (seq[k]) begin
      if ($urandom_range(0, 9) == 0) send_req(8'($urandom), 1'b1, 1'b0, 1'b1, 1'b0, STAT_OK);
      send_req(seq[k].data, seq[k].eo, seq[k].last, 1'b1, 1'b0, STAT_OK);
    end
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b0;
      ready_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    path_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte %h last %b status %0d",
                                out_byte, out_last, out_status));
      end else begin
        want = awaited.pop_front();
        if (out_byte !== want.data)
          flag_mismatch($sformatf("out_byte %h, want %h", out_byte, want.data));
        if (out_last !== want.last)
          flag_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
        if (out_status !== want.st)
          flag_mismatch($sformatf("out_status %0d, want %0d", out_status, want.st));
        if (want.st == STAT_OK) n_path_bytes++;
        else n_rejects++;
      end
    end
  end

  initial begin
    int path_no;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_COUNT; i++) begin
      calm = (i < 8);
      send_req(dir_rows[i].data, dir_rows[i].eo, dir_rows[i].last, 1'b1,
               dir_rows[i].typed, dir_rows[i].st);
    end
    path_no = 0;
    while (n_items < 100) begin
      calm = ($urandom_range(0, 3) == 0);
      random_path(path_no == 1);
      path_no++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d paths from %0d requests: %0d path bytes and %0d rejections checked",
             n_paths, n_items, n_path_bytes, n_rejects);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ups_pkg.sv
design/ups_dp.sv
design/ups_ctrl.sv
design/url_path_sanitizer.sv
test/tb.sv
